// File: rtl/core/qmn_pkg.sv
// Shared widths, codes and payload types for the quaternion multiply/normalize pipeline.
// No dependencies; every rtl/core module refers to this package by scoped names.
`timescale 1ns / 1ps

package qmn_pkg;

  localparam int FRAC_BITS  = 12;
  localparam int SQRT_GUARD = 6;
  localparam int TOL_FRAC   = 24;
  localparam int COMP_W     = 16;
  localparam int TOL_W      = 16;

  localparam int PROD_W = 2 * COMP_W + 2;          // exact sum of four products
  localparam int MAG_W  = PROD_W - 1 - FRAC_BITS;  // magnitude of one component
  localparam int SQ_W   = 2 * MAG_W;
  localparam int M_W    = SQ_W + 2;                // squared magnitude
  localparam int RAD_W  = M_W + 2 * SQRT_GUARD + (M_W % 2);
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int NUM_W  = MAG_W + FRAC_BITS + SQRT_GUARD;
  localparam int Q_W    = FRAC_BITS + 1;
  localparam int DIV_W  = NUM_W + ROOT_W;
  localparam int CMP_W  = M_W + TOL_FRAC + TOL_W;

  localparam int IN_W  = 136;
  localparam int OUT_W = 72;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(17);
  localparam logic [MAG_W-1:0] MAX_POS   = MAG_W'(2 ** (COMP_W - 1) - 1);
  localparam logic [MAG_W-1:0] MAX_NEG   = MAG_W'(2 ** (COMP_W - 1));
  localparam logic [COMP_W-1:0] SAT_POS  = COMP_W'(2 ** (COMP_W - 1) - 1);
  localparam logic [COMP_W-1:0] SAT_NEG  = COMP_W'(2 ** (COMP_W - 1));
  localparam int UNIT_Q = 2 ** FRAC_BITS;

  typedef enum logic [1:0] {
    ACT_MUL  = 2'd0,
    ACT_PASS = 2'd1,
    ACT_CONJ = 2'd2,
    ACT_RSVD = 2'd3
  } action_t;

  // Per-item data that rides alongside the root and divider stages.
  typedef struct packed {
    logic [3:0][MAG_W-1:0]  mag;
    logic [3:0]             neg;
    logic [3:0][COMP_W-1:0] pass;
    logic                   pass_clip;
    logic                   resc;
  } side_t;

endpackage

// File: rtl/core/quaternion_multiply_normalize.sv
// Top level of the quaternion multiply/normalize stream block.
// Depends on qmn_pkg, qmn_front, qmn_sqrt and qmn_div.
`timescale 1ns / 1ps

// Quaternion multiply / conjugate / normalize on Q3.12 components. Each input item
// selects an action (0: Hamilton product a*b, 1 or 3: a, 2: conjugate of a); the
// squared magnitude m of that intermediate is formed exactly, and when m is nonzero
// and |m - 1| exceeds unit_tolerance (units of 2^-24) every component is divided by
// floor(sqrt(m * 2^12)) after scaling by 2^18, rounding toward zero. Results saturate
// to 16 bits and flag it; a rescaled result never saturates. The block is a fully
// pipelined datapath: one item can enter every clock while the output is not held
// off, and each item passes through the front-end stages, the 28-stage square-root
// pipeline (one root bit per stage), the 13-stage divider (one quotient bit per
// stage, four lanes in parallel) and the output register on its way to the output.
// The whole pipeline advances together; when the output is held off, every stage
// holds and s_tready drops, so nothing is lost or repeated. Write unit_tolerance
// (cfg_wen/cfg_wdata) only while no item is in flight.
module quaternion_multiply_normalize (
  input  logic                        clk,
  input  logic                        rst,
  // tdata, low bit up: action[1:0], a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, zero pad
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [qmn_pkg::IN_W-1:0]    s_tdata,
  // tdata, low bit up: r_w, r_x, r_y, r_z, was_rescaled, saturated, zero pad
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [qmn_pkg::OUT_W-1:0]   m_tdata,
  input  logic                        cfg_wen,
  input  logic [qmn_pkg::TOL_W-1:0]   cfg_wdata
);

  localparam int CW = qmn_pkg::COMP_W;

  logic                         adv;
  logic [qmn_pkg::TOL_W-1:0]    tol;
  logic [1:0]                   action;
  logic [3:0][CW-1:0]           a_in;
  logic [3:0][CW-1:0]           b_in;

  // the pipeline moves whenever the output register is empty or being drained
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  assign action = s_tdata[1:0];
  for (genvar i = 0; i < 4; i++) begin : g_unpack
    assign a_in[i] = s_tdata[2 + i*CW +: CW];
    assign b_in[i] = s_tdata[2 + (4+i)*CW +: CW];
  end

  // tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= qmn_pkg::TOL_RESET;
    end else if (cfg_wen) begin
      tol <= cfg_wdata;
    end
  end

  logic                         fr_valid;
  logic [qmn_pkg::RAD_W-1:0]    fr_rad;
  qmn_pkg::side_t               fr_side;

  qmn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s_tvalid),
    .action    (action),
    .a         (a_in),
    .b         (b_in),
    .tol       (tol),
    .out_valid (fr_valid),
    .rad       (fr_rad),
    .side      (fr_side)
  );

  logic                         sq_valid;
  logic [qmn_pkg::ROOT_W-1:0]   sq_root;
  qmn_pkg::side_t               sq_side;

  qmn_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (fr_valid),
    .rad       (fr_rad),
    .in_side   (fr_side),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  logic                         dv_valid;
  logic [3:0][qmn_pkg::Q_W-1:0] dv_quot;
  qmn_pkg::side_t               dv_side;

  // a zero root only occurs for items that skip the rescale; their quotient is dropped
  qmn_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sq_valid),
    .divisor   (sq_root),
    .in_side   (sq_side),
    .out_valid (dv_valid),
    .quot      (dv_quot),
    .out_side  (dv_side)
  );

  // output register: pick rescaled quotient or saturated pass-through value
  logic [3:0][CW-1:0]           r_q;
  logic                         resc_q;
  logic                         sat_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        if (dv_side.resc) begin
          r_q[i] <= dv_side.neg[i] ? CW'(0) - CW'(dv_quot[i]) : CW'(dv_quot[i]);
        end else begin
          r_q[i] <= dv_side.pass[i];
        end
      end
      resc_q <= dv_side.resc;
      sat_q  <= !dv_side.resc && dv_side.pass_clip;
    end
  end

  assign m_tdata = {{(qmn_pkg::OUT_W - 4*CW - 2){1'b0}}, sat_q, resc_q, r_q};

  // a rescaled item can never clip
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(resc_q && sat_q))
    else $error("rescaled result flagged as saturated");

  // the rescaled scalar component stays within one unit in magnitude
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && resc_q) |->
      ($signed(r_q[0]) <= qmn_pkg::UNIT_Q && $signed(r_q[0]) >= -qmn_pkg::UNIT_Q))
    else $error("rescaled scalar component out of unit range");

  // while stalled, the root pipeline output must not move
  assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(sq_valid) && $stable(sq_root))
    else $error("square-root pipeline advanced during a stall");

endmodule

// File: rtl/core/qmn_front.sv
// Front end: product or selection, squared magnitude, tolerance decision (five stages).
// Depends on qmn_pkg.
`timescale 1ns / 1ps

module qmn_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  logic                               in_valid,
  input  logic [1:0]                         action,
  input  logic signed [3:0][qmn_pkg::COMP_W-1:0] a,
  input  logic signed [3:0][qmn_pkg::COMP_W-1:0] b,
  input  logic [qmn_pkg::TOL_W-1:0]          tol,
  output logic                               out_valid,
  output logic [qmn_pkg::RAD_W-1:0]          rad,
  output qmn_pkg::side_t                     side
);

  // stage 1: sixteen partial products
  logic                                v1;
  logic [1:0]                          act1;
  logic signed [qmn_pkg::COMP_W-1:0]   a1 [4];
  logic signed [2*qmn_pkg::COMP_W-1:0] p1 [4][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      act1 <= action;
      for (int i = 0; i < 4; i++) begin
        a1[i] <= $signed(a[i]);
        for (int j = 0; j < 4; j++) begin
          p1[i][j] <= $signed(a[i]) * $signed(b[j]);
        end
      end
    end
  end

  // stage 2: component sums, truncating shift, sign/magnitude split
  logic signed [qmn_pkg::PROD_W-1:0] sum [4];
  logic [qmn_pkg::MAG_W-1:0]         mag_c [4];
  logic [3:0]                        neg_c;
  logic                              v2;
  logic [qmn_pkg::MAG_W-1:0]         mag2 [4];
  logic [3:0]                        neg2;

  always_comb begin
    logic [qmn_pkg::PROD_W-1:0] abs_s;
    logic signed [qmn_pkg::COMP_W:0] ext;
    logic [qmn_pkg::COMP_W:0] abs_a;
    sum[0] = qmn_pkg::PROD_W'(p1[0][0]) - qmn_pkg::PROD_W'(p1[1][1])
           - qmn_pkg::PROD_W'(p1[2][2]) - qmn_pkg::PROD_W'(p1[3][3]);
    sum[1] = qmn_pkg::PROD_W'(p1[0][1]) + qmn_pkg::PROD_W'(p1[1][0])
           + qmn_pkg::PROD_W'(p1[2][3]) - qmn_pkg::PROD_W'(p1[3][2]);
    sum[2] = qmn_pkg::PROD_W'(p1[0][2]) - qmn_pkg::PROD_W'(p1[1][3])
           + qmn_pkg::PROD_W'(p1[2][0]) + qmn_pkg::PROD_W'(p1[3][1]);
    sum[3] = qmn_pkg::PROD_W'(p1[0][3]) + qmn_pkg::PROD_W'(p1[1][2])
           - qmn_pkg::PROD_W'(p1[2][1]) + qmn_pkg::PROD_W'(p1[3][0]);
    for (int i = 0; i < 4; i++) begin
      abs_s = sum[i][qmn_pkg::PROD_W-1] ? qmn_pkg::PROD_W'(-sum[i]) : qmn_pkg::PROD_W'(sum[i]);
      ext   = {a1[i][qmn_pkg::COMP_W-1], a1[i]};
      abs_a = ext[qmn_pkg::COMP_W] ? (qmn_pkg::COMP_W+1)'(-ext) : (qmn_pkg::COMP_W+1)'(ext);
      case (qmn_pkg::action_t'(act1))
        qmn_pkg::ACT_MUL: begin
          mag_c[i] = qmn_pkg::MAG_W'(abs_s >> qmn_pkg::FRAC_BITS);
          neg_c[i] = sum[i][qmn_pkg::PROD_W-1];
        end
        qmn_pkg::ACT_CONJ: begin
          mag_c[i] = qmn_pkg::MAG_W'(abs_a);
          neg_c[i] = (i == 0) ? ext[qmn_pkg::COMP_W] : ~ext[qmn_pkg::COMP_W];
        end
        default: begin
          mag_c[i] = qmn_pkg::MAG_W'(abs_a);
          neg_c[i] = ext[qmn_pkg::COMP_W];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag2 <= mag_c;
      neg2 <= neg_c;
    end
  end

  // stage 3: squares
  logic                      v3;
  logic [qmn_pkg::MAG_W-1:0] mag3 [4];
  logic [3:0]                neg3;
  logic [qmn_pkg::SQ_W-1:0]  sq3 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag3 <= mag2;
      neg3 <= neg2;
      for (int i = 0; i < 4; i++) begin
        sq3[i] <= mag2[i] * mag2[i];
      end
    end
  end

  // stage 4: squared magnitude and the saturated pass-through values
  logic                       v4;
  logic [qmn_pkg::MAG_W-1:0]  mag4 [4];
  logic [3:0]                 neg4;
  logic [qmn_pkg::M_W-1:0]    m4;
  logic [3:0][qmn_pkg::COMP_W-1:0] pass4;
  logic                       clip4;
  logic [3:0][qmn_pkg::COMP_W-1:0] pass_c;
  logic [3:0]                 clip_c;

  always_comb begin
    logic [qmn_pkg::MAG_W-1:0] negm;
    for (int i = 0; i < 4; i++) begin
      negm = qmn_pkg::MAG_W'(0) - mag3[i];
      if (neg3[i]) begin
        clip_c[i] = mag3[i] > qmn_pkg::MAX_NEG;
        pass_c[i] = clip_c[i] ? qmn_pkg::SAT_NEG : qmn_pkg::COMP_W'(negm);
      end else begin
        clip_c[i] = mag3[i] > qmn_pkg::MAX_POS;
        pass_c[i] = clip_c[i] ? qmn_pkg::SAT_POS : qmn_pkg::COMP_W'(mag3[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag4  <= mag3;
      neg4  <= neg3;
      m4    <= qmn_pkg::M_W'(sq3[0]) + qmn_pkg::M_W'(sq3[1])
             + qmn_pkg::M_W'(sq3[2]) + qmn_pkg::M_W'(sq3[3]);
      pass4 <= pass_c;
      clip4 <= |clip_c;
    end
  end

  // stage 5: deviation from one against the tolerance
  logic [qmn_pkg::M_W-1:0]   one_m;
  logic [qmn_pkg::M_W-1:0]   dev;
  logic [qmn_pkg::CMP_W-1:0] dev_ext;
  logic [qmn_pkg::CMP_W-1:0] tol_ext;
  logic                      resc_c;

  assign one_m   = qmn_pkg::M_W'(1) << (2 * qmn_pkg::FRAC_BITS);
  assign dev     = (m4 > one_m) ? m4 - one_m : one_m - m4;
  assign dev_ext = qmn_pkg::CMP_W'(dev) << qmn_pkg::TOL_FRAC;
  assign tol_ext = qmn_pkg::CMP_W'(tol) << (2 * qmn_pkg::FRAC_BITS);
  assign resc_c  = (m4 != '0) && (dev_ext > tol_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad            <= qmn_pkg::RAD_W'(m4) << (2 * qmn_pkg::SQRT_GUARD);
      for (int i = 0; i < 4; i++) begin
        side.mag[i]  <= mag4[i];
      end
      side.neg       <= neg4;
      side.pass      <= pass4;
      side.pass_clip <= clip4;
      side.resc      <= resc_c;
    end
  end

endmodule

// File: rtl/core/qmn_sqrt.sv
// Pipelined integer square root, one root bit per stage, with item sideband carried along.
// Depends on qmn_pkg.
`timescale 1ns / 1ps

module qmn_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [qmn_pkg::RAD_W-1:0]   rad,
  input  qmn_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic [qmn_pkg::ROOT_W-1:0]  root,
  output qmn_pkg::side_t              out_side
);

  localparam int N = qmn_pkg::ROOT_W;

  logic                        vld_r  [N];
  logic [qmn_pkg::REM_W-1:0]   rem_r  [N];
  logic [qmn_pkg::ROOT_W-1:0]  root_r [N];
  logic [qmn_pkg::RAD_W-1:0]   rad_r  [N];
  qmn_pkg::side_t              side_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                       v_p;
    logic [qmn_pkg::REM_W-1:0]  rem_p;
    logic [qmn_pkg::ROOT_W-1:0] root_p;
    logic [qmn_pkg::RAD_W-1:0]  rad_p;
    qmn_pkg::side_t             side_p;
    logic [qmn_pkg::REM_W-1:0]  rem_t;
    logic [qmn_pkg::REM_W-1:0]  trial;
    logic                       ge;

    if (k == 0) begin : g_first
      assign v_p    = in_valid;
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad;
      assign side_p = in_side;
    end else begin : g_next
      assign v_p    = vld_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign rad_p  = rad_r[k-1];
      assign side_p = side_r[k-1];
    end

    // bring down the next pair of radicand bits and try root*4+1
    assign rem_t = {rem_p[qmn_pkg::REM_W-3:0], rad_p[qmn_pkg::RAD_W-1 -: 2]};
    assign trial = {root_p, 2'b01};
    assign ge    = rem_t >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= ge ? rem_t - trial : rem_t;
        root_r[k] <= {root_p[qmn_pkg::ROOT_W-2:0], ge};
        rad_r[k]  <= rad_p << 2;
        side_r[k] <= side_p;
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign root      = root_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

// File: rtl/core/qmn_div.sv
// Four-lane pipelined restoring divider: |c| scaled up, divided by the root, one quotient
// bit per stage. Depends on qmn_pkg.
`timescale 1ns / 1ps

module qmn_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             adv,
  input  logic                             in_valid,
  input  logic [qmn_pkg::ROOT_W-1:0]       divisor,
  input  qmn_pkg::side_t                   in_side,
  output logic                             out_valid,
  output logic [3:0][qmn_pkg::Q_W-1:0]     quot,
  output qmn_pkg::side_t                   out_side
);

  localparam int N = qmn_pkg::Q_W;

  logic                             vld_r [N];
  logic [qmn_pkg::ROOT_W-1:0]       dv_r  [N];
  logic [3:0][qmn_pkg::NUM_W-1:0]   rem_r [N];
  logic [3:0][qmn_pkg::Q_W-1:0]     q_r   [N];
  qmn_pkg::side_t                   side_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int BIT = N - 1 - k;
    logic                           v_p;
    logic [qmn_pkg::ROOT_W-1:0]     dv_p;
    logic [3:0][qmn_pkg::NUM_W-1:0] rem_p;
    logic [3:0][qmn_pkg::Q_W-1:0]   q_p;
    qmn_pkg::side_t                 side_p;
    logic [qmn_pkg::DIV_W-1:0]      sub;
    logic [3:0][qmn_pkg::NUM_W-1:0] rem_n;
    logic [3:0][qmn_pkg::Q_W-1:0]   q_n;

    if (k == 0) begin : g_first
      assign v_p    = in_valid;
      assign dv_p   = divisor;
      assign side_p = in_side;
      assign q_p    = '0;
      for (genvar i = 0; i < 4; i++) begin : g_num
        assign rem_p[i] = qmn_pkg::NUM_W'(in_side.mag[i])
                          << (qmn_pkg::FRAC_BITS + qmn_pkg::SQRT_GUARD);
      end
    end else begin : g_next
      assign v_p    = vld_r[k-1];
      assign dv_p   = dv_r[k-1];
      assign side_p = side_r[k-1];
      assign q_p    = q_r[k-1];
      assign rem_p  = rem_r[k-1];
    end

    assign sub = qmn_pkg::DIV_W'(dv_p) << BIT;

    always_comb begin
      logic ge;
      for (int i = 0; i < 4; i++) begin
        ge       = qmn_pkg::DIV_W'(rem_p[i]) >= sub;
        rem_n[i] = ge ? rem_p[i] - qmn_pkg::NUM_W'(sub) : rem_p[i];
        q_n[i]   = {q_p[i][qmn_pkg::Q_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[k]   <= dv_p;
        rem_r[k]  <= rem_n;
        q_r[k]    <= q_n;
        side_r[k] <= side_p;
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign quot      = q_r[N-1];
  assign out_side  = side_r[N-1];

endmodule
